### sv/bacs_pkg.sv
// Package for the BCD alarm clock with snooze.
// Holds payload and register types, register indexes, alarm phase codes and
// the BCD split helpers. Depends on nothing.
package bacs_pkg;

  // One tick request carrying the button levels.
  typedef struct packed {
    logic off_pressed;
    logic snooze_pressed;
  } in_t;

  // One result: the current time as BCD digits plus the alarm status.
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic       tone_on;
    logic [2:0] alarm_phase;
  } out_t;

  // Time of day as BCD digits.
  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] hu;
    logic [2:0] mt;
    logic [3:0] mu;
    logic [2:0] st;
    logic [3:0] su;
  } time_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [4:0]  start_hours;
    logic [5:0]  start_minutes;
    logic [4:0]  alarm_hours;
    logic [5:0]  alarm_minutes;
    logic        run_enable;
    logic        alarm_armed;
    logic [7:0]  ticks_per_second;
    logic [15:0] snooze_ticks;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOURS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOURS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ARMED      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_TICKS     = 3'd7;

  localparam logic [7:0]  TPS_RESET    = 8'd4;
  localparam logic [15:0] SNOOZE_RESET = 16'd240;
  localparam logic [15:0] SNOOZE_MAX   = 16'hFFFF;

  // Alarm phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CHECK   = 3'd1;
  localparam logic [2:0] PH_RING    = 3'd2;
  localparam logic [2:0] PH_OFFWAIT = 3'd3;
  localparam logic [2:0] PH_SNOOZE  = 3'd4;

  localparam logic [4:0] MAX_HOURS   = 5'd23;
  localparam logic [5:0] MAX_MINUTES = 6'd59;

  // Clamp an hour to 23 and split it into tens (upper 2 bits) and units.
  function automatic logic [5:0] split_hours(input logic [4:0] h);
    logic [4:0] c;
    logic [4:0] u;
    logic [1:0] tens;
    c = (h > MAX_HOURS) ? MAX_HOURS : h;
    if (c >= 5'd20) begin
      tens = 2'd2;
      u = c - 5'd20;
    end else if (c >= 5'd10) begin
      tens = 2'd1;
      u = c - 5'd10;
    end else begin
      tens = 2'd0;
      u = c;
    end
    return {tens, u[3:0]};
  endfunction

  // Clamp a minute to 59 and split it into tens (upper 3 bits) and units.
  function automatic logic [6:0] split_minutes(input logic [5:0] m);
    logic [5:0] c;
    logic [5:0] u;
    logic [2:0] tens;
    c = (m > MAX_MINUTES) ? MAX_MINUTES : m;
    tens = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (c >= 6'(k * 10)) begin
        tens = 3'(k);
      end
    end
    u = c - 6'(6'(tens) * 6'd10);
    return {tens, u[3:0]};
  endfunction

endpackage

### sv/bcd_alarm_clock_with_snooze.sv
// BCD time-of-day clock with alarm and snooze; one tick request gives one result.
// A request accepted is held in the input register, then written into the result register.
// Throughput: one request per cycle; the time and alarm update is combinational between
// the input register and the result register, and a stalled result holds the input.
// Reset (rst, synchronous): clears both stages, time 00:00:00, alarm idle, registers to
// their defaults (4 ticks per second, 240 snooze ticks).
module bcd_alarm_clock_with_snooze (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bacs_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bacs_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bacs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bacs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bacs_pkg::cfg_t  cfg;
  bacs_pkg::time_t time_next;
  bacs_pkg::in_t   s1_data;
  logic            s1_valid;
  logic            s1_adv;
  logic            in_accept;
  logic [2:0]      phase_next;

  assign cfg_ready = 1'b1;

  bacs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= in_data;
    end
  end

  bacs_time u_time (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_adv),
    .cfg       (cfg),
    .time_next (time_next)
  );

  bacs_alarm u_alarm (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_adv),
    .cfg        (cfg),
    .now        (time_next),
    .buttons    (s1_data),
    .phase_next (phase_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.hour_tens    <= time_next.ht;
      out_data.hour_units   <= time_next.hu;
      out_data.minute_tens  <= time_next.mt;
      out_data.minute_units <= time_next.mu;
      out_data.second_tens  <= time_next.st;
      out_data.second_units <= time_next.su;
      out_data.tone_on      <= (phase_next == bacs_pkg::PH_RING);
      out_data.alarm_phase  <= phase_next;
    end
  end

`ifndef ASSERT_OFF
  // A tick processed while disarmed reports the idle phase.
  a_disarmed_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !cfg.alarm_armed) |=> (out_data.alarm_phase == bacs_pkg::PH_IDLE))
    else $error("alarm phase not idle while disarmed");

  // A tick processed while stopped shows seconds at zero.
  a_stopped_seconds: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !cfg.run_enable) |=>
      (out_data.second_tens == 3'd0 && out_data.second_units == 4'd0))
    else $error("seconds not held at zero while stopped");

  // Shown digits stay within BCD time ranges.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.second_tens <= 3'd5 && out_data.minute_tens <= 3'd5 &&
                   out_data.second_units <= 4'd9 && out_data.minute_units <= 4'd9 &&
                   out_data.hour_units <= 4'd9 && out_data.hour_tens <= 2'd2))
    else $error("time digit out of range");

  // The tone follows the ringing phase.
  a_tone_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.tone_on == (out_data.alarm_phase == bacs_pkg::PH_RING)))
    else $error("tone does not match ringing phase");
`endif

endmodule

### sv/bacs_cfg_regs.sv
// Configuration register file for the alarm clock.
// Depends on bacs_pkg for the register struct, indexes and reset values.
module bacs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [bacs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bacs_pkg::CFG_DATA_W-1:0]  wr_data,
  output bacs_pkg::cfg_t                   cfg
);

  // Write the addressed register; each one keeps only its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_hours      <= '0;
      cfg.start_minutes    <= '0;
      cfg.alarm_hours      <= '0;
      cfg.alarm_minutes    <= '0;
      cfg.run_enable       <= 1'b0;
      cfg.alarm_armed      <= 1'b0;
      cfg.ticks_per_second <= bacs_pkg::TPS_RESET;
      cfg.snooze_ticks     <= bacs_pkg::SNOOZE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bacs_pkg::CFG_START_HOURS:      cfg.start_hours      <= wr_data[4:0];
        bacs_pkg::CFG_START_MINUTES:    cfg.start_minutes    <= wr_data[5:0];
        bacs_pkg::CFG_ALARM_HOURS:      cfg.alarm_hours      <= wr_data[4:0];
        bacs_pkg::CFG_ALARM_MINUTES:    cfg.alarm_minutes    <= wr_data[5:0];
        bacs_pkg::CFG_RUN_ENABLE:       cfg.run_enable       <= wr_data[0];
        bacs_pkg::CFG_ALARM_ARMED:      cfg.alarm_armed      <= wr_data[0];
        bacs_pkg::CFG_TICKS_PER_SECOND: cfg.ticks_per_second <= wr_data[7:0];
        bacs_pkg::CFG_SNOOZE_TICKS:     cfg.snooze_ticks     <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/bacs_time.sv
// Tick prescaler and cascaded BCD time-of-day counters.
// Depends on bacs_pkg for the time and register structs and BCD helpers.
module bacs_time (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  bacs_pkg::cfg_t cfg,
  output bacs_pkg::time_t time_next
);

  bacs_pkg::time_t cur;
  logic [7:0]      tick_count;
  logic [7:0]      tick_count_next;
  logic [7:0]      period;
  logic [7:0]      tick_inc;
  logic [5:0]      start_h;
  logic [6:0]      start_m;

  // Next time: hold the start time while stopped, else count ticks and carry.
  always_comb begin
    period    = (cfg.ticks_per_second == 8'd0) ? 8'd1 : cfg.ticks_per_second;
    tick_inc  = tick_count + 8'd1;
    start_h   = bacs_pkg::split_hours(cfg.start_hours);
    start_m   = bacs_pkg::split_minutes(cfg.start_minutes);
    time_next = cur;
    tick_count_next = tick_count;
    if (!cfg.run_enable) begin
      time_next.ht = start_h[5:4];
      time_next.hu = start_h[3:0];
      time_next.mt = start_m[6:4];
      time_next.mu = start_m[3:0];
      time_next.st = 3'd0;
      time_next.su = 4'd0;
      tick_count_next = 8'd0;
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= period) begin
        tick_count_next = 8'd0;
        if (cur.su == 4'd9) begin
          time_next.su = 4'd0;
          if (cur.st == 3'd5) begin
            time_next.st = 3'd0;
            if (cur.mu == 4'd9) begin
              time_next.mu = 4'd0;
              if (cur.mt == 3'd5) begin
                time_next.mt = 3'd0;
                // Hours wrap from 23 to 00.
                if (cur.ht >= 2'd2 && cur.hu >= 4'd3) begin
                  time_next.ht = 2'd0;
                  time_next.hu = 4'd0;
                end else if (cur.hu >= 4'd9) begin
                  time_next.hu = 4'd0;
                  time_next.ht = cur.ht + 2'd1;
                end else begin
                  time_next.hu = cur.hu + 4'd1;
                end
              end else begin
                time_next.mt = cur.mt + 3'd1;
              end
            end else begin
              time_next.mu = cur.mu + 4'd1;
            end
          end else begin
            time_next.st = cur.st + 3'd1;
          end
        end else begin
          time_next.su = cur.su + 4'd1;
        end
      end
    end
  end

  // Time and prescaler advance once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      tick_count <= 8'd0;
    end else if (en) begin
      cur        <= time_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

### sv/bacs_alarm.sv
// Alarm state machine with snooze counter.
// Depends on bacs_pkg for phase codes and the time and register structs.
module bacs_alarm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bacs_pkg::cfg_t  cfg,
  input  bacs_pkg::time_t now,
  input  bacs_pkg::in_t   buttons,
  output logic [2:0]      phase_next
);

  logic [2:0]  phase;
  logic [15:0] snooze_count;
  logic [15:0] snooze_count_next;
  logic [5:0]  hours;
  logic [6:0]  mins;
  logic        match;

  // Compare the updated time against the alarm time in binary.
  assign hours = 6'(6'(now.ht) * 6'd10) + 6'(now.hu);
  assign mins  = 7'(7'(now.mt) * 7'd10) + 7'(now.mu);
  assign match = (hours == 6'(cfg.alarm_hours)) && (mins == 7'(cfg.alarm_minutes));

  // Phase transition, then the snooze counter action of the new phase.
  always_comb begin
    if (!cfg.alarm_armed) begin
      phase_next = bacs_pkg::PH_IDLE;
    end else begin
      case (phase)
        bacs_pkg::PH_IDLE:    phase_next = bacs_pkg::PH_CHECK;
        bacs_pkg::PH_CHECK:   phase_next = match ? bacs_pkg::PH_RING : bacs_pkg::PH_CHECK;
        bacs_pkg::PH_RING: begin
          if (buttons.off_pressed) begin
            phase_next = bacs_pkg::PH_OFFWAIT;
          end else if (buttons.snooze_pressed) begin
            phase_next = bacs_pkg::PH_SNOOZE;
          end else begin
            phase_next = bacs_pkg::PH_RING;
          end
        end
        bacs_pkg::PH_OFFWAIT:
          phase_next = buttons.off_pressed ? bacs_pkg::PH_OFFWAIT : bacs_pkg::PH_CHECK;
        bacs_pkg::PH_SNOOZE:
          phase_next = (snooze_count >= cfg.snooze_ticks) ? bacs_pkg::PH_RING
                                                           : bacs_pkg::PH_SNOOZE;
        default:              phase_next = bacs_pkg::PH_IDLE;
      endcase
    end

    snooze_count_next = snooze_count;
    if (phase_next == bacs_pkg::PH_IDLE || phase_next == bacs_pkg::PH_RING) begin
      snooze_count_next = 16'd0;
    end else if (phase_next == bacs_pkg::PH_SNOOZE &&
                 snooze_count != bacs_pkg::SNOOZE_MAX) begin
      snooze_count_next = snooze_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bacs_pkg::PH_IDLE;
      snooze_count <= 16'd0;
    end else if (en) begin
      phase        <= phase_next;
      snooze_count <= snooze_count_next;
    end
  end

endmodule

### tb/sv/bcd_alarm_clock_with_snooze_checker.sv
`timescale 1ns / 1ps
// Checker for the BCD alarm clock with snooze: watches the tick, result and
// register channels, predicts each result and compares it field by field.
// Depends on bacs_pkg for the payload, register and phase definitions.
module bcd_alarm_clock_with_snooze_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  bacs_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  bacs_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bacs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              readings_checked
);

  // Shadow copy of the register file and of the clock and alarm state.
  bacs_pkg::cfg_t  settings;
  bacs_pkg::time_t clock_now;
  logic [7:0]      tick_cnt;
  logic [2:0]      phase;
  logic [15:0]     silence_cnt;

  // Predicted results, oldest first.
  bacs_pkg::out_t expected_readings[$];

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Advance the time by one base tick, then step the alarm on the new time.
  task automatic advance_clock(input bacs_pkg::in_t buttons, output bacs_pkg::out_t reading);
    int         hrs;
    int         mins;
    int         hours_now;
    int         mins_now;
    logic [7:0] period;
    logic [2:0] nxt;
    logic       hit;
    period = (settings.ticks_per_second == 8'd0) ? 8'd1 : settings.ticks_per_second;
    if (!settings.run_enable) begin
      // Hold the start time, clamped into range, with seconds at zero.
      hrs  = (settings.start_hours > bacs_pkg::MAX_HOURS) ? int'(bacs_pkg::MAX_HOURS)
                                                          : int'(settings.start_hours);
      mins = (settings.start_minutes > bacs_pkg::MAX_MINUTES) ? int'(bacs_pkg::MAX_MINUTES)
                                                              : int'(settings.start_minutes);
      clock_now.ht = 2'(hrs / 10);
      clock_now.hu = 4'(hrs % 10);
      clock_now.mt = 3'(mins / 10);
      clock_now.mu = 4'(mins % 10);
      clock_now.st = 3'd0;
      clock_now.su = 4'd0;
      tick_cnt     = 8'd0;
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= period) begin
        tick_cnt = 8'd0;
        // Cascaded BCD carries: seconds, minutes, then hours wrapping at 24.
        clock_now.su = clock_now.su + 4'd1;
        if (clock_now.su > 4'd9) begin
          clock_now.su = 4'd0;
          clock_now.st = clock_now.st + 3'd1;
          if (clock_now.st > 3'd5) begin
            clock_now.st = 3'd0;
            clock_now.mu = clock_now.mu + 4'd1;
            if (clock_now.mu > 4'd9) begin
              clock_now.mu = 4'd0;
              clock_now.mt = clock_now.mt + 3'd1;
              if (clock_now.mt > 3'd5) begin
                clock_now.mt = 3'd0;
                clock_now.hu = clock_now.hu + 4'd1;
                if (clock_now.ht >= 2'd2 && clock_now.hu > 4'd3) begin
                  clock_now.ht = 2'd0;
                  clock_now.hu = 4'd0;
                end else if (clock_now.hu > 4'd9) begin
                  clock_now.hu = 4'd0;
                  clock_now.ht = clock_now.ht + 2'd1;
                end
              end
            end
          end
        end
      end
    end

    // Alarm transition on the updated time.
    hours_now = int'(clock_now.ht) * 10 + int'(clock_now.hu);
    mins_now  = int'(clock_now.mt) * 10 + int'(clock_now.mu);
    hit = (hours_now == int'(settings.alarm_hours)) &&
          (mins_now == int'(settings.alarm_minutes));
    if (!settings.alarm_armed) begin
      nxt = bacs_pkg::PH_IDLE;
    end else begin
      case (phase)
        bacs_pkg::PH_IDLE:    nxt = bacs_pkg::PH_CHECK;
        bacs_pkg::PH_CHECK:   nxt = hit ? bacs_pkg::PH_RING : bacs_pkg::PH_CHECK;
        bacs_pkg::PH_RING: begin
          if (buttons.off_pressed) nxt = bacs_pkg::PH_OFFWAIT;
          else if (buttons.snooze_pressed) nxt = bacs_pkg::PH_SNOOZE;
          else nxt = bacs_pkg::PH_RING;
        end
        bacs_pkg::PH_OFFWAIT:
          nxt = buttons.off_pressed ? bacs_pkg::PH_OFFWAIT : bacs_pkg::PH_CHECK;
        bacs_pkg::PH_SNOOZE:
          nxt = (silence_cnt >= settings.snooze_ticks) ? bacs_pkg::PH_RING
                                                        : bacs_pkg::PH_SNOOZE;
        default:              nxt = bacs_pkg::PH_IDLE;
      endcase
    end
    phase = nxt;

    // The snooze counter clears in idle and ringing, and saturates while snoozing.
    if (nxt == bacs_pkg::PH_IDLE || nxt == bacs_pkg::PH_RING) begin
      silence_cnt = 16'd0;
    end else if (nxt == bacs_pkg::PH_SNOOZE && silence_cnt != bacs_pkg::SNOOZE_MAX) begin
      silence_cnt = silence_cnt + 16'd1;
    end

    reading.hour_tens    = clock_now.ht;
    reading.hour_units   = clock_now.hu;
    reading.minute_tens  = clock_now.mt;
    reading.minute_units = clock_now.mu;
    reading.second_tens  = clock_now.st;
    reading.second_units = clock_now.su;
    reading.tone_on      = (phase == bacs_pkg::PH_RING);
    reading.alarm_phase  = phase;
  endtask

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin : watch
    bacs_pkg::out_t want;
    bacs_pkg::out_t reading;
    if (rst) begin
      settings                  = '0;
      settings.ticks_per_second = bacs_pkg::TPS_RESET;
      settings.snooze_ticks     = bacs_pkg::SNOOZE_RESET;
      clock_now                 = '0;
      tick_cnt                  = 8'd0;
      phase                     = bacs_pkg::PH_IDLE;
      silence_cnt               = 16'd0;
      expected_readings.delete();
      mismatches                = 0;
      readings_checked          = 0;
    end else begin
      // Compare an accepted result against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = expected_readings.pop_front();
          check_field("hour_tens", out_data.hour_tens, want.hour_tens);
          check_field("hour_units", out_data.hour_units, want.hour_units);
          check_field("minute_tens", out_data.minute_tens, want.minute_tens);
          check_field("minute_units", out_data.minute_units, want.minute_units);
          check_field("second_tens", out_data.second_tens, want.second_tens);
          check_field("second_units", out_data.second_units, want.second_units);
          check_field("tone_on", out_data.tone_on, want.tone_on);
          check_field("alarm_phase", out_data.alarm_phase, want.alarm_phase);
          readings_checked++;
        end
      end

      // Track register writes; bits above each register's width are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bacs_pkg::CFG_START_HOURS:      settings.start_hours      = cfg_data[4:0];
          bacs_pkg::CFG_START_MINUTES:    settings.start_minutes    = cfg_data[5:0];
          bacs_pkg::CFG_ALARM_HOURS:      settings.alarm_hours      = cfg_data[4:0];
          bacs_pkg::CFG_ALARM_MINUTES:    settings.alarm_minutes    = cfg_data[5:0];
          bacs_pkg::CFG_RUN_ENABLE:       settings.run_enable       = cfg_data[0];
          bacs_pkg::CFG_ALARM_ARMED:      settings.alarm_armed      = cfg_data[0];
          bacs_pkg::CFG_TICKS_PER_SECOND: settings.ticks_per_second = cfg_data[7:0];
          bacs_pkg::CFG_SNOOZE_TICKS:     settings.snooze_ticks     = cfg_data[15:0];
          default: ;
        endcase
      end

      // Each accepted tick request yields exactly one result.
      if (in_valid && !in_stall) begin
        advance_clock(in_data, reading);
        expected_readings.push_back(reading);
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

### tb/sv/bcd_alarm_clock_with_snooze_tb.sv
`timescale 1ns / 1ps
// Top of the BCD alarm clock testbench: clock, reset, tick and register stimulus
// with random idling, and the verdict. Depends on bacs_pkg, the block and the checker.
module bcd_alarm_clock_with_snooze_tb;

  localparam int TICK_TARGET = 420;
  localparam int DATA_W      = bacs_pkg::CFG_DATA_W;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  bacs_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_stall;
  bacs_pkg::out_t                  out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bacs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0]               cfg_data;

  int            mismatches;
  int            outstanding;
  int            readings_checked;
  int            ticks_sent;
  int            writes_done;
  int            phases_run;
  bit            calm;
  bacs_pkg::in_t held_buttons;

  bcd_alarm_clock_with_snooze dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcd_alarm_clock_with_snooze_checker watcher (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .readings_checked (readings_checked)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net: end the run if the handshakes ever hang.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Idle length: mostly none or short, now and then long; none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Button levels tend to be held over several ticks, like a real press.
  function automatic bacs_pkg::in_t next_buttons();
    bacs_pkg::in_t b;
    int            r;
    b = held_buttons;
    if ($urandom_range(0, 9) < 4) begin
      r = $urandom_range(0, 99);
      b.off_pressed    = (r >= 70 && r < 85) || r >= 95;
      b.snooze_pressed = (r >= 85);
    end
    held_buttons = b;
    return b;
  endfunction

  // Result side stalls at random.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Write one register, with random junk above its width. Valid stays high
  // so that back-to-back writes need no bubble; the caller lowers it.
  task automatic write_reg(input logic [bacs_pkg::CFG_IDX_W-1:0] idx, input int value,
                           input int width);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] junk;
    mask = (width >= DATA_W) ? '1 : DATA_W'((1 << width) - 1);
    junk = ($urandom_range(0, 1) == 0) ? '0 : DATA_W'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (DATA_W'(value) & mask) | (junk & ~mask);
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
  endtask

  // Send one tick request after a random gap.
  task automatic send_tick(input bacs_pkg::in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic send_buttons(input logic off_b, input logic snz_b);
    bacs_pkg::in_t b;
    b.off_pressed    = off_b;
    b.snooze_pressed = snz_b;
    send_tick(b);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random phase: load a start time near a carry, aim the alarm, then run.
  task automatic run_phase();
    int   sh;
    int   sm;
    int   ah;
    int   am;
    int   ch;
    int   cm;
    int   tps_v;
    int   snz_v;
    int   burst;
    logic run_v;
    logic arm_v;
    calm = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0: sh = 23;
      1: sh = $urandom_range(24, 31);
      2: sh = 9 + 10 * $urandom_range(0, 1);
      default: sh = $urandom_range(0, 23);
    endcase
    sm = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : $urandom_range(57, 59);
    case ($urandom_range(0, 3))
      0, 1: begin
        ah = sh;
        am = sm;
      end
      2: begin
        // Alarm one minute after the clamped start time.
        ch = (sh > 23) ? 23 : sh;
        cm = ((sm > 59) ? 59 : sm) + 1;
        if (cm == 60) begin
          cm = 0;
          ch = (ch + 1) % 24;
        end
        ah = ch;
        am = cm;
      end
      default: begin
        ah = $urandom_range(0, 31);
        am = $urandom_range(0, 63);
      end
    endcase
    case ($urandom_range(0, 5))
      0: tps_v = 0;
      1: tps_v = 255;
      2: tps_v = $urandom_range(1, 255);
      default: tps_v = $urandom_range(1, 3);
    endcase
    case ($urandom_range(0, 5))
      0: snz_v = 0;
      1: snz_v = 65535;
      2: snz_v = $urandom_range(0, 65535);
      default: snz_v = $urandom_range(1, 20);
    endcase
    run_v = ($urandom_range(0, 4) != 0);
    arm_v = ($urandom_range(0, 6) != 0);
    burst = $urandom_range(20, 70);

    write_reg(bacs_pkg::CFG_RUN_ENABLE, 0, 1);
    write_reg(bacs_pkg::CFG_START_HOURS, sh, 5);
    write_reg(bacs_pkg::CFG_START_MINUTES, sm, 6);
    write_reg(bacs_pkg::CFG_ALARM_HOURS, ah, 5);
    write_reg(bacs_pkg::CFG_ALARM_MINUTES, am, 6);
    write_reg(bacs_pkg::CFG_ALARM_ARMED, arm_v, 1);
    write_reg(bacs_pkg::CFG_TICKS_PER_SECOND, tps_v, 8);
    write_reg(bacs_pkg::CFG_SNOOZE_TICKS, snz_v, 16);
    cfg_valid <= 1'b0;

    // A couple of ticks with the clock stopped load the start time.
    repeat (2) send_tick(next_buttons());
    settle();

    write_reg(bacs_pkg::CFG_RUN_ENABLE, run_v, 1);
    cfg_valid <= 1'b0;
    repeat (burst) send_tick(next_buttons());
    settle();
    phases_run++;
  endtask

  // Main stimulus.
  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    held_buttons = '0;
    calm         = 1'b0;
    ticks_sent   = 0;
    writes_done  = 0;
    phases_run   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: the clock holds 00:00:00 and the buttons do nothing.
    send_buttons(1'b1, 1'b1);
    send_buttons(1'b0, 1'b0);
    send_buttons(1'b1, 1'b0);
    settle();

    // Out-of-range start time clamps to 23:59, which the alarm matches.
    // Zero tick period and zero snooze length are set as well.
    write_reg(bacs_pkg::CFG_START_HOURS, 31, 5);
    write_reg(bacs_pkg::CFG_START_MINUTES, 63, 6);
    write_reg(bacs_pkg::CFG_ALARM_HOURS, 23, 5);
    write_reg(bacs_pkg::CFG_ALARM_MINUTES, 59, 6);
    write_reg(bacs_pkg::CFG_TICKS_PER_SECOND, 0, 8);
    write_reg(bacs_pkg::CFG_SNOOZE_TICKS, 0, 16);
    write_reg(bacs_pkg::CFG_ALARM_ARMED, 1, 1);
    cfg_valid <= 1'b0;
    send_buttons(1'b0, 1'b0);  // idle to checking
    send_buttons(1'b0, 1'b0);  // match, ringing
    send_buttons(1'b0, 1'b1);  // snooze
    send_buttons(1'b0, 1'b0);  // zero snooze length rings again at once
    send_buttons(1'b1, 1'b1);  // off wins over snooze
    send_buttons(1'b1, 1'b0);  // off still held
    send_buttons(1'b0, 1'b0);  // released, back to checking
    send_buttons(1'b0, 1'b0);  // still the alarm minute, rings again
    settle();

    // Run with a zero period so every tick is a second; one-tick snooze.
    write_reg(bacs_pkg::CFG_RUN_ENABLE, 1, 1);
    write_reg(bacs_pkg::CFG_SNOOZE_TICKS, 1, 16);
    cfg_valid <= 1'b0;
    send_buttons(1'b0, 1'b1);
    send_buttons(1'b0, 1'b0);
    send_buttons(1'b0, 1'b1);
    send_buttons(1'b0, 1'b0);
    settle();

    // An alarm time out of range never matches.
    write_reg(bacs_pkg::CFG_ALARM_HOURS, 24, 5);
    write_reg(bacs_pkg::CFG_ALARM_MINUTES, 60, 6);
    cfg_valid <= 1'b0;
    send_buttons(1'b1, 1'b0);
    send_buttons(1'b0, 1'b0);
    send_buttons(1'b0, 1'b0);
    settle();

    // Disarming forces idle; largest tick period and snooze length.
    write_reg(bacs_pkg::CFG_ALARM_ARMED, 0, 1);
    write_reg(bacs_pkg::CFG_TICKS_PER_SECOND, 255, 8);
    write_reg(bacs_pkg::CFG_SNOOZE_TICKS, 65535, 16);
    cfg_valid <= 1'b0;
    send_buttons(1'b1, 1'b1);
    send_buttons(1'b0, 1'b0);
    settle();

    // Random phases until enough ticks have gone through.
    while (ticks_sent < TICK_TARGET) begin
      run_phase();
    end

    // Let the pipeline drain and catch any stray result.
    calm = 1'b1;
    settle();
    repeat (10) @(posedge clk);

    $display("Ran %0d tick requests over %0d random phases with %0d register writes.",
             ticks_sent, phases_run, writes_done);
    $display("Compared %0d results, %0d mismatches.", readings_checked, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
